@@ rtl/call_site_statistics_table_unit_macros.svh @@
// Assertion macros used by the checker file.
// Depends on nothing; each macro expects clk and rst_n in scope.
`ifndef CALL_SITE_STATISTICS_TABLE_UNIT_MACROS_SVH
`define CALL_SITE_STATISTICS_TABLE_UNIT_MACROS_SVH

// same-cycle implication
`define CSST_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CSST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/csst_pkg.sv @@
// Package for the call-site statistics table: codes, entry type, value widening.
// Depends on nothing.
package csst_pkg;

    localparam logic [31:0] HASH_MUL = 32'd2654435761;

    localparam logic [1:0] MODE_RECORD = 2'd0;
    localparam logic [1:0] MODE_SLOT   = 2'd1;
    localparam logic [1:0] MODE_TOTALS = 2'd2;

    localparam logic [2:0] STAT_HIT      = 3'd0;
    localparam logic [2:0] STAT_INSERTED = 3'd1;
    localparam logic [2:0] STAT_DROPPED  = 3'd2;
    localparam logic [2:0] STAT_DISABLED = 3'd3;
    localparam logic [2:0] STAT_EMPTY    = 3'd4;
    localparam logic [2:0] STAT_OCCUPIED = 3'd5;
    localparam logic [2:0] STAT_TOTALS   = 3'd6;

    localparam logic [2:0] KIND_S8   = 3'd0;
    localparam logic [2:0] KIND_U8   = 3'd1;
    localparam logic [2:0] KIND_S16  = 3'd2;
    localparam logic [2:0] KIND_U16  = 3'd3;
    localparam logic [2:0] KIND_BOOL = 3'd4;

    // remainder unit: 4 hash bits per cycle over the 32 hash bits
    localparam int MOD_DIGITS = 4;
    localparam logic [2:0] MOD_LAST = 3'd7;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_MOD,
        S_FETCH,
        S_PROBE,
        S_UPDATE,
        S_RESULT
    } csst_state_t;

    typedef struct packed {
        logic [31:0] function_id;
        logic [31:0] address;
        logic [2:0]  kind;
        logic [31:0] calls;
        logic [31:0] raw_bad;
        logic [31:0] ret_bad;
    } entry_t;

    typedef struct packed {
        logic [31:0] raw;
        logic [16:0] ext;
    } sample_t;

    function automatic logic [31:0] widen(input logic [31:0] raw, input logic [2:0] kind);
        logic [31:0] r;
        begin
            case (kind)
                KIND_S8:  r = {{24{raw[7]}}, raw[7:0]};
                KIND_S16: r = {{16{raw[15]}}, raw[15:0]};
                KIND_U16: r = {16'd0, raw[15:0]};
                default:  r = {24'd0, raw[7:0]};
            endcase
            widen = r;
        end
    endfunction

endpackage

@@ rtl/call_site_statistics_table_unit.sv @@
// Call-site statistics table: hashed open-addressing table with linear probing.
// Depends on csst_pkg.
//
//  channel | direction | handshake          | beat
//  --------+-----------+--------------------+------------------------------------
//  in      | in        | in_valid/in_stall  | mode, values, kind, key, slot, sample
//  out     | out       | out_valid/out_stall| status, slot, site and sample fields
//  cfg     | in        | cfg_valid/cfg_ready| cfg_data -> recorder_enable
//
// After reset the entry memory is swept to zero, with the input stalled.
// A record hashes the key, fetches the start slot, probes (one entry memory read per
// cycle) and updates; a record with a zero function id goes straight to the update,
// a slot read just fetches its slot, and totals and disabled records go to the result.
// A non power-of-two SITES adds a remainder step after the hash or before a slot fetch.
// The result register frees the input side: a held result only blocks the next one.
module call_site_statistics_table_unit
    import csst_pkg::*;
#(
    parameter int SITES   = 8192,
    parameter int SAMPLES = 3
)
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_data,
    // input beat
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         mode,
    input  logic signed [31:0] raw_value,
    input  logic signed [31:0] returned_value,
    input  logic [2:0]         width_kind,
    input  logic [31:0]        function_id,
    input  logic [31:0]        return_address,
    input  logic [12:0]        slot_index,
    input  logic [1:0]         sample_index,
    // result beat
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         status,
    output logic [13:0]        slot,
    output logic signed [16:0] extended_value,
    output logic [31:0]        site_function,
    output logic [31:0]        site_address,
    output logic [2:0]         site_kind,
    output logic [31:0]        calls_count,
    output logic [31:0]        raw_bad_count,
    output logic [31:0]        ret_bad_count,
    output logic [1:0]         sample_count,
    output logic [31:0]        sample_raw,
    output logic signed [16:0] sample_extended
);

    localparam int IDX_W = $clog2(SITES);
    localparam int CNT_W = $clog2(SAMPLES + 1);
    localparam int SA_W  = $clog2(SITES * SAMPLES);
    localparam int USE_W = $clog2(SITES + 1);
    localparam bit POW2  = ((SITES & (SITES - 1)) == 0);
    localparam logic [IDX_W:0]   SITES_C = (IDX_W + 1)'(SITES);
    localparam logic [IDX_W-1:0] LAST_C  = IDX_W'(SITES - 1);

    typedef struct packed {
        entry_t           ent;
        logic [CNT_W-1:0] cnt;
    } word_t;

    // storage: one entry word per slot, SAMPLES sample words per slot
    word_t   ent_mem [SITES];
    sample_t smp_mem [SITES * SAMPLES];

    csst_state_t state_reg, state_next;

    logic [IDX_W-1:0] clr_reg;
    logic             enable_reg;
    logic [31:0]      total_calls_reg, total_raw_reg, total_ret_reg, dropped_reg;
    logic [USE_W-1:0] sites_reg;
    logic [2:0]       mod_cnt_reg;
    logic             out_valid_reg;

    // item payload
    logic [1:0]       mode_reg;
    logic [31:0]      raw_reg, ret_reg, fid_reg, ra_reg;
    logic [2:0]       kind_reg;
    logic [1:0]       sample_reg;
    logic [31:0]      modv_reg;
    logic [IDX_W-1:0] rem_reg, cur_reg, probe_cnt_reg;
    logic [2:0]       stat_reg;
    logic             found_reg, fwd_reg;
    word_t            word_reg, ent_rd_reg;
    sample_t          smp_rd_reg;

    // memory port controls
    logic             ent_re, ent_we, smp_re, smp_we;
    logic [IDX_W-1:0] ent_raddr, ent_waddr;
    word_t            ent_wdata;
    logic [SA_W-1:0]  smp_raddr, smp_waddr;
    sample_t          smp_wdata;

    // datapath
    logic [31:0]      ext32;
    logic             raw_bad, ret_bad;
    logic [IDX_W-1:0] rem_next, start_idx, cur_inc;
    logic             p_hit, p_empty, p_last, p_stop;
    word_t            upd_word, res_word;
    logic             wr_sample, sample_ok, out_free, show_site, smp_shown;

    assign ext32   = widen(raw_reg, kind_reg);
    assign raw_bad = raw_reg != ext32;
    assign ret_bad = ret_reg != ext32;

    // remainder of modv by SITES, four bits per cycle
    always_comb
    begin
        logic [IDX_W:0] r;
        r = {1'b0, rem_reg};
        for (int k = 0; k < MOD_DIGITS; k++)
        begin
            r = {r[IDX_W-1:0], modv_reg[31-k]};
            if (r >= SITES_C)
                r = r - SITES_C;
        end
        rem_next = r[IDX_W-1:0];
    end

    assign start_idx = POW2 ? modv_reg[IDX_W-1:0] : rem_reg;
    assign cur_inc   = (cur_reg == LAST_C) ? '0 : cur_reg + 1'b1;

    assign p_hit   = ent_rd_reg.ent.function_id == fid_reg && ent_rd_reg.ent.address == ra_reg;
    assign p_empty = ent_rd_reg.ent.function_id == 32'd0;
    assign p_last  = probe_cnt_reg == LAST_C;
    assign p_stop  = p_hit || p_empty || p_last;

    assign sample_ok = 32'(sample_reg) < SAMPLES;
    assign wr_sample = raw_bad && (32'(ent_rd_reg.cnt) < SAMPLES);

    // entry after the record update
    always_comb
    begin
        upd_word = ent_rd_reg;
        if (stat_reg == STAT_INSERTED)
        begin
            upd_word.ent.function_id = fid_reg;
            upd_word.ent.address     = ra_reg;
            upd_word.ent.kind        = kind_reg;
        end
        upd_word.ent.calls = ent_rd_reg.ent.calls + 32'd1;
        if (raw_bad)
            upd_word.ent.raw_bad = ent_rd_reg.ent.raw_bad + 32'd1;
        if (ret_bad)
            upd_word.ent.ret_bad = ent_rd_reg.ent.ret_bad + 32'd1;
        if (wr_sample)
            upd_word.cnt = ent_rd_reg.cnt + 1'b1;
    end

    assign out_free  = !out_valid_reg || !out_stall;
    assign res_word  = (mode_reg == MODE_SLOT) ? ent_rd_reg : word_reg;
    assign show_site = (mode_reg == MODE_SLOT) || found_reg;
    assign smp_shown = show_site && sample_ok && (32'(sample_reg) < 32'(res_word.cnt));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:  if (clr_reg == LAST_C) state_next = S_IDLE;
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (mode)
                        MODE_RECORD:
                            if (!enable_reg)
                                state_next = S_RESULT;
                            else if (function_id == 32'd0)
                                state_next = S_UPDATE;
                            else
                                state_next = S_HASH;
                        MODE_SLOT:   state_next = POW2 ? S_FETCH : S_MOD;
                        MODE_TOTALS: state_next = S_RESULT;
                        default:     state_next = S_IDLE;
                    endcase
                end
            end
            S_HASH:   state_next = POW2 ? S_FETCH : S_MOD;
            S_MOD:    if (mod_cnt_reg == MOD_LAST) state_next = S_FETCH;
            S_FETCH:  state_next = (mode_reg == MODE_SLOT) ? S_RESULT : S_PROBE;
            S_PROBE:  if (p_stop) state_next = S_UPDATE;
            S_UPDATE: state_next = S_RESULT;
            S_RESULT: if (out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // memory port controls and the input stall
    always_comb
    begin
        in_stall  = state_reg != S_IDLE;
        ent_re    = 1'b0;
        ent_raddr = cur_inc;
        ent_we    = 1'b0;
        ent_waddr = cur_reg;
        ent_wdata = upd_word;
        smp_re    = 1'b0;
        smp_raddr = SA_W'(cur_reg) * SA_W'(SAMPLES) + SA_W'(sample_reg);
        smp_we    = 1'b0;
        smp_waddr = SA_W'(cur_reg) * SA_W'(SAMPLES) + SA_W'(ent_rd_reg.cnt);
        smp_wdata = '{raw: raw_reg, ext: ext32[16:0]};
        unique case (state_reg)
            S_CLEAR:
            begin
                ent_we    = 1'b1;
                ent_waddr = clr_reg;
                ent_wdata = '0;
            end
            S_FETCH:
            begin
                ent_re    = 1'b1;
                ent_raddr = start_idx;
                smp_re    = (mode_reg == MODE_SLOT) && sample_ok;
                smp_raddr = SA_W'(start_idx) * SA_W'(SAMPLES) + SA_W'(sample_reg);
            end
            S_PROBE:  ent_re = !p_stop;
            S_UPDATE:
            begin
                ent_we = found_reg;
                smp_we = found_reg && wr_sample;
                smp_re = found_reg && sample_ok;
            end
            default:  ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ent_we)
            ent_mem[ent_waddr] <= ent_wdata;
        if (ent_re)
            ent_rd_reg <= ent_mem[ent_raddr];
        if (smp_we)
            smp_mem[smp_waddr] <= smp_wdata;
        if (smp_re)
            smp_rd_reg <= smp_mem[smp_raddr];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_reg         <= '0;
            enable_reg      <= 1'b0;
            total_calls_reg <= '0;
            total_raw_reg   <= '0;
            total_ret_reg   <= '0;
            dropped_reg     <= '0;
            sites_reg       <= '0;
            mod_cnt_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
                enable_reg <= cfg_data;
            if (state_reg == S_CLEAR)
                clr_reg <= clr_reg + 1'b1;
            if (state_reg == S_MOD)
                mod_cnt_reg <= mod_cnt_reg + 1'b1;
            else
                mod_cnt_reg <= '0;
            if (state_reg == S_UPDATE)
            begin
                total_calls_reg <= total_calls_reg + 32'd1;
                if (raw_bad)
                    total_raw_reg <= total_raw_reg + 32'd1;
                if (ret_bad)
                    total_ret_reg <= total_ret_reg + 32'd1;
                if (!found_reg)
                    dropped_reg <= dropped_reg + 32'd1;
                if (stat_reg == STAT_INSERTED)
                    sites_reg <= sites_reg + 1'b1;
            end
            if (state_reg == S_RESULT && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // item datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    mode_reg   <= mode;
                    raw_reg    <= raw_value;
                    ret_reg    <= returned_value;
                    kind_reg   <= width_kind;
                    fid_reg    <= function_id;
                    ra_reg     <= return_address;
                    sample_reg <= sample_index;
                    modv_reg   <= 32'(slot_index);
                    rem_reg    <= '0;
                    found_reg  <= 1'b0;
                    fwd_reg    <= 1'b0;
                    stat_reg   <= enable_reg ? STAT_DROPPED : STAT_DISABLED;
                end
            S_HASH:
            begin
                modv_reg <= (ra_reg * HASH_MUL) ^ fid_reg;
                rem_reg  <= '0;
            end
            S_MOD:
            begin
                modv_reg <= modv_reg << MOD_DIGITS;
                rem_reg  <= rem_next;
            end
            S_FETCH:
            begin
                cur_reg       <= start_idx;
                probe_cnt_reg <= '0;
            end
            S_PROBE:
                if (p_hit)
                begin
                    stat_reg  <= STAT_HIT;
                    found_reg <= 1'b1;
                end
                else if (p_empty)
                begin
                    stat_reg  <= STAT_INSERTED;
                    found_reg <= 1'b1;
                end
                else if (!p_last)
                begin
                    cur_reg       <= cur_inc;
                    probe_cnt_reg <= probe_cnt_reg + 1'b1;
                end
            S_UPDATE:
            begin
                word_reg <= upd_word;
                // new sample lands at the index being read back
                fwd_reg  <= wr_sample && (32'(sample_reg) == 32'(ent_rd_reg.cnt));
            end
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (state_reg == S_RESULT && out_free)
        begin
            extended_value  <= (mode_reg == MODE_RECORD) ? ext32[16:0] : 17'sd0;
            site_function   <= show_site ? res_word.ent.function_id : 32'd0;
            site_address    <= show_site ? res_word.ent.address : 32'd0;
            site_kind       <= show_site ? res_word.ent.kind : 3'd0;
            sample_count    <= show_site ? 2'(res_word.cnt) : 2'd0;
            sample_extended <= !smp_shown ? 17'sd0 : fwd_reg ? ext32[16:0] : smp_rd_reg.ext;
            if (mode_reg == MODE_TOTALS)
            begin
                status        <= STAT_TOTALS;
                slot          <= 14'(sites_reg);
                calls_count   <= total_calls_reg;
                raw_bad_count <= total_raw_reg;
                ret_bad_count <= total_ret_reg;
                sample_raw    <= dropped_reg;
            end
            else
            begin
                if (mode_reg == MODE_SLOT)
                    status <= (res_word.ent.function_id != 32'd0) ? STAT_OCCUPIED : STAT_EMPTY;
                else
                    status <= stat_reg;
                slot          <= show_site ? 14'(cur_reg) : 14'(SITES);
                calls_count   <= show_site ? res_word.ent.calls : 32'd0;
                raw_bad_count <= show_site ? res_word.ent.raw_bad : 32'd0;
                ret_bad_count <= show_site ? res_word.ent.ret_bad : 32'd0;
                sample_raw    <= !smp_shown ? 32'd0 : fwd_reg ? raw_reg : smp_rd_reg.raw;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign cfg_ready = 1'b1;

endmodule

@@ rtl/csst_checker.sv @@
// Port-level checker for the call-site statistics table, with its bind.
// Depends on csst_pkg and call_site_statistics_table_unit_macros.svh.
`include "call_site_statistics_table_unit_macros.svh"

module csst_checker
    import csst_pkg::*;
#(
    parameter int SITES = 8192
)
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  status,
    input logic [13:0] slot,
    input logic [31:0] site_function,
    input logic [31:0] calls_count
);

    `CSST_ASSERT_NEXT(a_hold_valid, out_valid && out_stall, out_valid, "result dropped while stalled")
    `CSST_ASSERT_NEXT(a_hold_status, out_valid && out_stall, $stable(status), "status moved while stalled")
    `CSST_ASSERT_NOW(a_disabled, out_valid && status == STAT_DISABLED, slot == 14'(SITES) && calls_count == 32'd0, "disabled record shows a site")
    `CSST_ASSERT_NOW(a_empty, out_valid && status == STAT_EMPTY, site_function == 32'd0, "empty slot shows a key")

endmodule

bind call_site_statistics_table_unit csst_checker #(.SITES(SITES)) u_csst_checker (.*);
